/* src/qske_pkg.sv */
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator: shared definitions
// Field widths, register indexes, term selector codes, limits and the item
// types of the request and response channels.
// ----------------------------------------------------------------------------
package qske_pkg;

   // Default number of fraction bits used inside the term datapath.
   localparam int FRAC_BITS_DEFAULT = 16;

   // Fixed field widths.
   localparam int OP_W       = 2;
   localparam int DIST_W     = 32;
   localparam int RH_W       = 32;
   localparam int FACTOR_W   = 48;
   localparam int RESULT_W   = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 48;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RECIPROCAL_H     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_FACTOR     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRADIENT_FACTOR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LAPLACIAN_FACTOR = 2'd3;

   // Reset value of one over smoothing length (1.0 in Q16.16).
   localparam logic [RH_W-1:0] RECIPROCAL_H_RESET = 32'h0001_0000;

   // Term selector codes.
   localparam logic [OP_W-1:0] OP_VALUE     = 2'd0;
   localparam logic [OP_W-1:0] OP_GRADIENT  = 2'd1;
   localparam logic [OP_W-1:0] OP_LAPLACIAN = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED    = 2'd3;

   // Saturation limits of the Q24.24 result, as raw bit patterns.
   localparam logic [RESULT_W-1:0] RESULT_POS_LIMIT = 48'h7FFF_FFFF_FFFF;
   localparam logic [RESULT_W-1:0] RESULT_NEG_LIMIT = 48'h8000_0000_0000;

   // Request item.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [DIST_W-1:0] distance;
   } req_type;

   // Response item.
   typedef struct packed {
      logic signed [RESULT_W-1:0] kernel_result;
      logic                       saturated;
   } rsp_type;

   // Control that travels with an item through the term pipeline.
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            zero;   // result is forced to zero
   } term_ctrl_type;

endpackage

/* src/qske_front.sv */
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator: front end
// Two stages: the exact distance times reciprocal product, then the scaled
// radius s and the three bases (3-s), (2-s) and (1-s).
// ----------------------------------------------------------------------------
module qske_front
   import qske_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   localparam int XW = FRAC_BITS + 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  req_type       in_item,
   input  logic [RH_W-1:0] reciprocal_h,
   output logic          out_valid,
   input  logic          out_ready,
   output term_ctrl_type out_ctrl,
   output logic [XW-1:0] out_a,
   output logic [XW-1:0] out_b,
   output logic [XW-1:0] out_c
);

   localparam int PROD_W = DIST_W + RH_W;
   localparam logic [XW-1:0] ONE_X   = XW'(1) << FRAC_BITS;
   localparam logic [XW-1:0] TWO_X   = XW'(2) << FRAC_BITS;
   localparam logic [XW-1:0] THREE_X = XW'(3) << FRAC_BITS;

   logic              v1_ff, v2_ff;
   logic              en1, en2;
   logic [OP_W-1:0]   op1_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [33:0]       s3;
   logic [XW-1:0]     s;
   term_ctrl_type     ctrl_in, ctrl_ff;
   logic [XW-1:0]     a_in, b_in, c_in;
   logic [XW-1:0]     a_ff, b_ff, c_ff;

   // A stage takes a new item when it is empty or its content moves on.
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // Stage one: exact Q32.32 product.
   assign prod_in = PROD_W'(in_item.distance) * PROD_W'(reciprocal_h);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         op1_ff  <= in_item.op;
         prod_ff <= prod_in;
      end
   end

   // Stage two: s = 3 * product, truncated, and the bases of the three terms.
   always_comb begin
      s3 = {2'b00, prod_ff[31:0]} + {1'b0, prod_ff[31:0], 1'b0};
      s  = s3[33 -: XW];
      ctrl_in.op   = op1_ff;
      ctrl_in.zero = (prod_ff[PROD_W-1:32] != '0) || (op1_ff == OP_UNUSED);
      a_in = THREE_X - s;
      b_in = (s < TWO_X) ? (TWO_X - s) : '0;
      c_in = (s < ONE_X) ? (ONE_X - s) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         ctrl_ff <= ctrl_in;
         a_ff    <= a_in;
         b_ff    <= b_in;
         c_ff    <= c_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_c     = c_ff;

endmodule

/* src/qske_power_stage.sv */
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator: power stage
// One step of the power chain for the three bases at once. Step STEP raises
// each running power by one degree when the selected term needs it, and
// otherwise passes the running power through.
// ----------------------------------------------------------------------------
module qske_power_stage
   import qske_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int STEP = 1,
   localparam int XW = FRAC_BITS + 2,
   localparam int PW = FRAC_BITS + 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  term_ctrl_type in_ctrl,
   input  logic [XW-1:0] in_base_a,
   input  logic [XW-1:0] in_base_b,
   input  logic [XW-1:0] in_base_c,
   input  logic [PW-1:0] in_acc_a,
   input  logic [PW-1:0] in_acc_b,
   input  logic [PW-1:0] in_acc_c,
   output logic          out_valid,
   input  logic          out_ready,
   output term_ctrl_type out_ctrl,
   output logic [XW-1:0] out_base_a,
   output logic [XW-1:0] out_base_b,
   output logic [XW-1:0] out_base_c,
   output logic [PW-1:0] out_acc_a,
   output logic [PW-1:0] out_acc_b,
   output logic [PW-1:0] out_acc_c
);

   localparam int MUL_W = PW + XW;

   logic          v_ff, en;
   logic          do_mul;
   logic [MUL_W-1:0] mul_a, mul_b, mul_c;
   logic [PW-1:0] acc_a_in, acc_b_in, acc_c_in;
   logic [PW-1:0] acc_a_ff, acc_b_ff, acc_c_ff;
   logic [XW-1:0] base_a_ff, base_b_ff, base_c_ff;
   term_ctrl_type ctrl_ff;

   assign en       = !v_ff || out_ready;
   assign in_ready = en;

   // The value term is a fifth power, the derivative a fourth, the Laplacian a cube.
   always_comb begin
      case (in_ctrl.op)
         OP_VALUE:     do_mul = (STEP < 5);
         OP_GRADIENT:  do_mul = (STEP < 4);
         OP_LAPLACIAN: do_mul = (STEP < 3);
         default:      do_mul = 1'b0;
      endcase
   end

   // Multiply and truncate back to the working fraction width.
   always_comb begin
      mul_a = MUL_W'(in_acc_a) * MUL_W'(in_base_a);
      mul_b = MUL_W'(in_acc_b) * MUL_W'(in_base_b);
      mul_c = MUL_W'(in_acc_c) * MUL_W'(in_base_c);
      acc_a_in = do_mul ? mul_a[FRAC_BITS +: PW] : in_acc_a;
      acc_b_in = do_mul ? mul_b[FRAC_BITS +: PW] : in_acc_b;
      acc_c_in = do_mul ? mul_c[FRAC_BITS +: PW] : in_acc_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctrl_ff   <= in_ctrl;
         base_a_ff <= in_base_a;
         base_b_ff <= in_base_b;
         base_c_ff <= in_base_c;
         acc_a_ff  <= acc_a_in;
         acc_b_ff  <= acc_b_in;
         acc_c_ff  <= acc_c_in;
      end
   end

   assign out_valid  = v_ff;
   assign out_ctrl   = ctrl_ff;
   assign out_base_a = base_a_ff;
   assign out_base_b = base_b_ff;
   assign out_base_c = base_c_ff;
   assign out_acc_a  = acc_a_ff;
   assign out_acc_b  = acc_b_ff;
   assign out_acc_c  = acc_c_ff;

endmodule

/* src/qske_scale.sv */
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator: back end
// Five stages: weighted sum and magnitude, high factor product, low factor
// product, recombination, then saturation and sign restoration.
// ----------------------------------------------------------------------------
module qske_scale
   import qske_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   localparam int PW = FRAC_BITS + 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  term_ctrl_type       in_ctrl,
   input  logic [PW-1:0]       in_pow_a,
   input  logic [PW-1:0]       in_pow_b,
   input  logic [PW-1:0]       in_pow_c,
   input  logic [FACTOR_W-1:0] value_factor,
   input  logic [FACTOR_W-1:0] gradient_factor,
   input  logic [FACTOR_W-1:0] laplacian_factor,
   output logic                out_valid,
   input  logic                out_ready,
   output rsp_type             out_item
);

   localparam int NSTAGE = 5;
   localparam int SUMW   = FRAC_BITS + 11;
   localparam int MW     = FRAC_BITS + 10;
   localparam int HALF_W = FACTOR_W / 2;
   localparam int BIGW   = MW + HALF_W;
   localparam int LOWW   = BIGW - FRAC_BITS;
   localparam int SH     = HALF_W - FRAC_BITS;
   localparam int BSH_W  = RESULT_W - 1;

   logic [NSTAGE-1:0] v_ff, en;

   logic signed [SUMW-1:0] ea, eb, ec, sum;
   logic [SUMW-1:0]        mag;
   logic [FACTOR_W-1:0]    factor_in;

   logic                zero_a_ff, neg_a_ff;
   logic [MW-1:0]       m_a_ff;
   logic [FACTOR_W-1:0] factor_a_ff;

   logic                zero_b_ff, neg_b_ff;
   logic [MW-1:0]       m_b_ff;
   logic [HALF_W-1:0]   lo_b_ff;
   logic [BIGW-1:0]     big_b_ff;

   logic                zero_c_ff, neg_c_ff, ovf_c_ff;
   logic [BSH_W-1:0]    bsh_c_ff;
   logic [LOWW-1:0]     low_c_ff;
   logic [BIGW-1:0]     low_prod;

   logic                zero_d_ff, neg_d_ff, ovf_d_ff;
   logic [RESULT_W-1:0] r_d_ff;

   logic [RESULT_W-1:0] mag_e;
   rsp_type             rsp_in, rsp_ff;

   // Backward enable chain: a stage moves when it is empty or the next moves.
   always_comb begin
      en[NSTAGE-1] = !v_ff[NSTAGE-1] || out_ready;
      for (int i = NSTAGE - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < NSTAGE; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Stage A: a^n - 6 b^n + 15 c^n, its sign and magnitude, and the factor.
   always_comb begin
      ea  = $signed(SUMW'(in_pow_a));
      eb  = $signed(SUMW'(in_pow_b));
      ec  = $signed(SUMW'(in_pow_c));
      sum = ea - (eb <<< 2) - (eb <<< 1) + (ec <<< 4) - ec;
      mag = sum[SUMW-1] ? $unsigned(-sum) : $unsigned(sum);
      case (in_ctrl.op)
         OP_VALUE:     factor_in = value_factor;
         OP_GRADIENT:  factor_in = gradient_factor;
         OP_LAPLACIAN: factor_in = laplacian_factor;
         default:      factor_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         zero_a_ff   <= in_ctrl.zero;
         neg_a_ff    <= sum[SUMW-1];
         m_a_ff      <= mag[MW-1:0];
         factor_a_ff <= factor_in;
      end
   end

   // Stage B: magnitude times the upper half of the factor.
   always_ff @(posedge clock) begin
      if (en[1]) begin
         zero_b_ff <= zero_a_ff;
         neg_b_ff  <= neg_a_ff;
         m_b_ff    <= m_a_ff;
         lo_b_ff   <= factor_a_ff[HALF_W-1:0];
         big_b_ff  <= BIGW'(m_a_ff) * BIGW'(factor_a_ff[FACTOR_W-1:HALF_W]);
      end
   end

   // Stage C: magnitude times the lower half; overflow test on the upper product.
   assign low_prod = BIGW'(m_b_ff) * BIGW'(lo_b_ff);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         zero_c_ff <= zero_b_ff;
         neg_c_ff  <= neg_b_ff;
         ovf_c_ff  <= (big_b_ff[BIGW-1:FRAC_BITS+23] != '0);
         bsh_c_ff  <= BSH_W'(big_b_ff[FRAC_BITS+22:0]) << SH;
         low_c_ff  <= low_prod[BIGW-1:FRAC_BITS];
      end
   end

   // Stage D: recombine the two partial products.
   always_ff @(posedge clock) begin
      if (en[3]) begin
         zero_d_ff <= zero_c_ff;
         neg_d_ff  <= neg_c_ff;
         ovf_d_ff  <= ovf_c_ff;
         r_d_ff    <= RESULT_W'(bsh_c_ff) + RESULT_W'(low_c_ff);
      end
   end

   // Stage E: clip to the signed range and restore the sign.
   always_comb begin
      mag_e  = r_d_ff;
      rsp_in.saturated = 1'b0;
      if (!neg_d_ff) begin
         if (ovf_d_ff || (r_d_ff > RESULT_POS_LIMIT)) begin
            mag_e = RESULT_POS_LIMIT;
            rsp_in.saturated = 1'b1;
         end
         rsp_in.kernel_result = $signed(mag_e);
      end else begin
         if (ovf_d_ff || (r_d_ff > RESULT_NEG_LIMIT)) begin
            mag_e = RESULT_NEG_LIMIT;
            rsp_in.saturated = 1'b1;
         end
         rsp_in.kernel_result = $signed(RESULT_W'(0) - mag_e);
      end
      if (zero_d_ff) begin
         rsp_in.kernel_result = '0;
         rsp_in.saturated     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = v_ff[NSTAGE-1];
   assign out_item  = rsp_ff;

endmodule

/* src/quintic_spline_kernel_eval.sv */
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator: top level
// Configuration registers and the eleven-stage evaluation pipeline.
// ----------------------------------------------------------------------------
// The block accepts one item (term selector and Q16.16 distance) in every
// clock cycle while the response side is not stalled, and returns one Q24.24
// result with a saturation flag per item, in order. The pipeline is made of
// two front-end stages (distance product, scaled radius and bases), four
// power stages (one multiply each) and five back-end stages (weighted sum,
// two factor products, recombination and saturation). Every stage holds its
// item while the one after it is full, so a stalled response fills the empty
// stages before the request side is held. Registers may be written only while
// no item is in flight.
// ----------------------------------------------------------------------------
module quintic_spline_kernel_eval
   import qske_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int XW     = FRAC_BITS + 2;
   localparam int PW     = FRAC_BITS + 8;
   localparam int NPOWER = 4;

   logic [RH_W-1:0]     reciprocal_h_ff;
   logic [FACTOR_W-1:0] value_factor_ff, gradient_factor_ff, laplacian_factor_ff;

   logic          valid_w [0:NPOWER];
   logic          ready_w [0:NPOWER];
   term_ctrl_type ctrl_w  [0:NPOWER];
   logic [XW-1:0] base_a_w [0:NPOWER];
   logic [XW-1:0] base_b_w [0:NPOWER];
   logic [XW-1:0] base_c_w [0:NPOWER];
   logic [PW-1:0] acc_a_w  [0:NPOWER];
   logic [PW-1:0] acc_b_w  [0:NPOWER];
   logic [PW-1:0] acc_c_w  [0:NPOWER];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         reciprocal_h_ff     <= RECIPROCAL_H_RESET;
         value_factor_ff     <= '0;
         gradient_factor_ff  <= '0;
         laplacian_factor_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RECIPROCAL_H:     reciprocal_h_ff     <= csr_data[RH_W-1:0];
            CSR_VALUE_FACTOR:     value_factor_ff     <= csr_data[FACTOR_W-1:0];
            CSR_GRADIENT_FACTOR:  gradient_factor_ff  <= csr_data[FACTOR_W-1:0];
            CSR_LAPLACIAN_FACTOR: laplacian_factor_ff <= csr_data[FACTOR_W-1:0];
            default: ;
         endcase
      end
   end

   // Front end: product, scaled radius and bases.
   qske_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_item      (req),
      .reciprocal_h (reciprocal_h_ff),
      .out_valid    (valid_w[0]),
      .out_ready    (ready_w[0]),
      .out_ctrl     (ctrl_w[0]),
      .out_a        (base_a_w[0]),
      .out_b        (base_b_w[0]),
      .out_c        (base_c_w[0])
   );

   // The running power starts as the base itself.
   assign acc_a_w[0] = PW'(base_a_w[0]);
   assign acc_b_w[0] = PW'(base_b_w[0]);
   assign acc_c_w[0] = PW'(base_c_w[0]);

   // Power chain: one multiply per stage, up to the fifth power.
   for (genvar k = 0; k < NPOWER; k++) begin : g_power
      qske_power_stage #(
         .FRAC_BITS (FRAC_BITS),
         .STEP      (k + 1)
      ) u_power (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (valid_w[k]),
         .in_ready   (ready_w[k]),
         .in_ctrl    (ctrl_w[k]),
         .in_base_a  (base_a_w[k]),
         .in_base_b  (base_b_w[k]),
         .in_base_c  (base_c_w[k]),
         .in_acc_a   (acc_a_w[k]),
         .in_acc_b   (acc_b_w[k]),
         .in_acc_c   (acc_c_w[k]),
         .out_valid  (valid_w[k+1]),
         .out_ready  (ready_w[k+1]),
         .out_ctrl   (ctrl_w[k+1]),
         .out_base_a (base_a_w[k+1]),
         .out_base_b (base_b_w[k+1]),
         .out_base_c (base_c_w[k+1]),
         .out_acc_a  (acc_a_w[k+1]),
         .out_acc_b  (acc_b_w[k+1]),
         .out_acc_c  (acc_c_w[k+1])
      );
   end

   // Back end: weighted sum, scaling and saturation.
   qske_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (valid_w[NPOWER]),
      .in_ready         (ready_w[NPOWER]),
      .in_ctrl          (ctrl_w[NPOWER]),
      .in_pow_a         (acc_a_w[NPOWER]),
      .in_pow_b         (acc_b_w[NPOWER]),
      .in_pow_c         (acc_c_w[NPOWER]),
      .value_factor     (value_factor_ff),
      .gradient_factor  (gradient_factor_ff),
      .laplacian_factor (laplacian_factor_ff),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_item         (rsp)
   );

endmodule

/* src/qske_checker.sv */
// ----------------------------------------------------------------------------
// Quintic spline kernel evaluator: port checker
// Concurrent assertions on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module qske_checker
   import qske_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp
);

   // A response item that is not taken stays on the port unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response item changed or vanished while stalled");

   // A saturated item carries one of the two range limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.saturated |->
         ($unsigned(rsp.kernel_result) == RESULT_POS_LIMIT) ||
         ($unsigned(rsp.kernel_result) == RESULT_NEG_LIMIT))
      else $error("saturation flag set on a result that is not a limit");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // With no result waiting, every stage can move, so a request is taken.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side held while the output stage is empty");

   // After reset no response can appear before the first item has passed
   // through every stage of the pipeline.
   a_no_shortcut: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !rsp_valid [*10])
      else $error("response appeared without passing the pipeline");

endmodule

bind quintic_spline_kernel_eval qske_checker u_qske_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
